// File: rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int NUM_WIDTH = 32;
   localparam int DEN_WIDTH = 31;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_EQ  = 3'd4,
      OP_LT  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_DIV_ZERO = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]                  op;
      logic signed [NUM_WIDTH-1:0] lhs_num;
      logic signed [NUM_WIDTH-1:0] lhs_den;
      logic signed [NUM_WIDTH-1:0] rhs_num;
      logic signed [NUM_WIDTH-1:0] rhs_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_WIDTH-1:0] res_num;
      logic [DEN_WIDTH-1:0]        res_den;
      logic                        compare_flag;
      logic [1:0]                  status;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_SEL_L,
      CMD_SEL_R,
      CMD_ZERO,
      CMD_GCD_INIT,
      CMD_GCD_STEP,
      CMD_GCD_FIN,
      CMD_DIV_INIT_N,
      CMD_DIV_INIT_D,
      CMD_DIV_STEP,
      CMD_DIV_SAVE_N,
      CMD_DIV_SAVE_D,
      CMD_ST_L,
      CMD_ST_R,
      CMD_MUL_P,
      CMD_MUL_Q,
      CMD_MUL_D,
      CMD_MUL_M,
      CMD_MUL_DVN,
      CMD_MUL_DVD,
      CMD_ADD,
      CMD_OUT_RES,
      CMD_OUT_CMP,
      CMD_OUT_ZD,
      CMD_OUT_DZ,
      CMD_OUT_NONE
   } cmd_type;

   typedef struct packed {
      logic       zero_den;
      logic       x_zero;
      logic       gcd_done;
      logic       div_last;
      logic       r_zero;
      logic [2:0] op;
   } dp_stat_type;

endpackage
`default_nettype wire

// File: rtl/core/rational_arithmetic_unit.sv
`default_nettype none
// Rational arithmetic unit: each transfer on start (taken when busy is low) carries an op
// code and two fractions; the unit reduces both operands to lowest terms, applies the op,
// reduces the result of ADD, SUB, MUL and DIV (EQ and LT give only compare_flag) and
// presents it on rsp_data for exactly one cycle with rsp_valid, which the receiver cannot
// stall. A zero denominator skips the rest: S_CHECK goes straight to S_OUT_ZD. Most of
// an item's time goes to the reduction passes (up to three): the shared binary GCD
// unit takes one step per cycle, and the bit-serial restoring divider then divides the
// numerator and then the denominator by the GCD. busy is high from the transfer until the
// cycle in which the result is presented. In that cycle the next transfer can already be
// taken.
module rational_arithmetic_unit #(
   parameter int VALUE_WIDTH = rau_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  rau_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   rau_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rau_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// File: rtl/core/rau_datapath.sv
`default_nettype none
module rau_datapath #(
   parameter int VALUE_WIDTH = rau_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire                   clock,
   input  rau_pkg::cmd_type      cmd,
   input  rau_pkg::req_type      req_data,
   output rau_pkg::dp_stat_type  stat,
   output rau_pkg::rsp_type      rsp_data
);
   import rau_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int DW = 2 * VALUE_WIDTH;
   localparam int KW = $clog2(DW + 1);
   localparam int CW = $clog2(DW);
   localparam logic [DW-1:0] LIM = DW'((64'd1 << (W - 1)) - 64'd1);

   logic [2:0]    op_ff;
   logic          zden_ff;
   logic          ln_ff, rn_ff, xs_ff;
   logic [W-1:0]  lm_ff, ld_ff, rm_ff, rd_ff;
   logic [DW-1:0] xn_ff, xd_ff, p_ff, q_ff;
   logic [DW-1:0] u_ff, v_ff, g_ff, n_ff, r_ff, qt_ff;
   logic [KW-1:0] k_ff;
   logic [CW-1:0] cnt_ff;
   rsp_type       rsp_ff;

   logic [W-1:0]  an_v, ad_v, bn_v, bd_v;
   logic [W-1:0]  am, adm, bm, bdm;
   logic [W-1:0]  mul_a, mul_b;
   logic [DW-1:0] prod;
   logic [DW:0]   r_sh;
   logic          r_ge;
   logic          qs;
   logic [DW-1:0] sum_m;
   logic          sum_s;
   logic          lt_flag, eq_flag;
   logic signed [W-1:0] out_num;

   assign an_v = req_data.lhs_num[W-1:0];
   assign ad_v = req_data.lhs_den[W-1:0];
   assign bn_v = req_data.rhs_num[W-1:0];
   assign bd_v = req_data.rhs_den[W-1:0];
   assign am   = an_v[W-1] ? W'(-an_v) : an_v;
   assign adm  = ad_v[W-1] ? W'(-ad_v) : ad_v;
   assign bm   = bn_v[W-1] ? W'(-bn_v) : bn_v;
   assign bdm  = bd_v[W-1] ? W'(-bd_v) : bd_v;

   always_comb begin
      mul_a = lm_ff;
      mul_b = rd_ff;
      case (cmd)
         CMD_MUL_Q: begin
            mul_a = rm_ff;
            mul_b = ld_ff;
         end
         CMD_MUL_D: begin
            mul_a = ld_ff;
            mul_b = rd_ff;
         end
         CMD_MUL_M: begin
            mul_a = lm_ff;
            mul_b = rm_ff;
         end
         CMD_MUL_DVD: begin
            mul_a = ld_ff;
            mul_b = rm_ff;
         end
         default: begin
            mul_a = lm_ff;
            mul_b = rd_ff;
         end
      endcase
   end
   assign prod = DW'(mul_a) * DW'(mul_b);

   assign r_sh = {r_ff, n_ff[DW-1]};
   assign r_ge = r_sh >= {1'b0, g_ff};

   always_comb begin
      qs = (op_ff == OP_SUB) ? ((q_ff != '0) ? !rn_ff : 1'b0) : rn_ff;
      if (ln_ff == qs) begin
         sum_s = ln_ff;
         sum_m = p_ff + q_ff;
      end else if (p_ff >= q_ff) begin
         sum_s = ln_ff;
         sum_m = p_ff - q_ff;
      end else begin
         sum_s = qs;
         sum_m = q_ff - p_ff;
      end
      if (sum_m == '0) sum_s = 1'b0;
   end

   assign eq_flag = (ln_ff == rn_ff) && (lm_ff == rm_ff) && (ld_ff == rd_ff);
   always_comb begin
      if (ln_ff != rn_ff) lt_flag = ln_ff;
      else if (!ln_ff) lt_flag = p_ff < q_ff;
      else lt_flag = p_ff > q_ff;
   end

   assign out_num = xs_ff ? W'(-xn_ff[W-1:0]) : xn_ff[W-1:0];

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            op_ff   <= req_data.op;
            zden_ff <= (adm == '0) || (bdm == '0);
            lm_ff   <= am;
            ld_ff   <= adm;
            rm_ff   <= bm;
            rd_ff   <= bdm;
            ln_ff   <= an_v[W-1] ^ ad_v[W-1];
            rn_ff   <= bn_v[W-1] ^ bd_v[W-1];
         end
         CMD_SEL_L: begin
            xs_ff <= ln_ff;
            xn_ff <= DW'(lm_ff);
            xd_ff <= DW'(ld_ff);
         end
         CMD_SEL_R: begin
            xs_ff <= rn_ff;
            xn_ff <= DW'(rm_ff);
            xd_ff <= DW'(rd_ff);
         end
         CMD_ZERO: begin
            xs_ff <= 1'b0;
            xd_ff <= DW'(1);
         end
         CMD_GCD_INIT: begin
            u_ff <= xn_ff;
            v_ff <= xd_ff;
            k_ff <= '0;
         end
         CMD_GCD_STEP: begin
            if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_ff <= (u_ff - v_ff) >> 1;
            end else begin
               v_ff <= (v_ff - u_ff) >> 1;
            end
         end
         CMD_GCD_FIN: g_ff <= u_ff << k_ff;
         CMD_DIV_INIT_N: begin
            n_ff   <= xn_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         CMD_DIV_INIT_D: begin
            n_ff   <= xd_ff;
            r_ff   <= '0;
            cnt_ff <= '0;
         end
         CMD_DIV_STEP: begin
            n_ff   <= n_ff << 1;
            r_ff   <= r_ge ? DW'(r_sh - {1'b0, g_ff}) : r_sh[DW-1:0];
            qt_ff  <= {qt_ff[DW-2:0], r_ge};
            cnt_ff <= cnt_ff + CW'(1);
         end
         CMD_DIV_SAVE_N: xn_ff <= qt_ff;
         CMD_DIV_SAVE_D: xd_ff <= qt_ff;
         CMD_ST_L: begin
            ln_ff <= xs_ff;
            lm_ff <= xn_ff[W-1:0];
            ld_ff <= xd_ff[W-1:0];
         end
         CMD_ST_R: begin
            rn_ff <= xs_ff;
            rm_ff <= xn_ff[W-1:0];
            rd_ff <= xd_ff[W-1:0];
         end
         CMD_MUL_P: p_ff <= prod;
         CMD_MUL_Q: q_ff <= prod;
         CMD_MUL_D: xd_ff <= prod;
         CMD_MUL_M: begin
            xn_ff <= prod;
            xs_ff <= ln_ff ^ rn_ff;
         end
         CMD_MUL_DVN: begin
            xn_ff <= prod;
            xs_ff <= ln_ff ^ rn_ff;
         end
         CMD_MUL_DVD: xd_ff <= prod;
         CMD_ADD: begin
            xs_ff <= sum_s;
            xn_ff <= sum_m;
         end
         CMD_OUT_RES: begin
            rsp_ff.compare_flag <= 1'b0;
            if ((xn_ff > LIM) || (xd_ff > LIM)) begin
               rsp_ff.res_num <= '0;
               rsp_ff.res_den <= '0;
               rsp_ff.status  <= ST_OVERFLOW;
            end else begin
               rsp_ff.res_num <= NUM_WIDTH'(out_num);
               rsp_ff.res_den <= DEN_WIDTH'(xd_ff[W-2:0]);
               rsp_ff.status  <= ST_OK;
            end
         end
         CMD_OUT_CMP: begin
            rsp_ff.res_num      <= '0;
            rsp_ff.res_den      <= '0;
            rsp_ff.compare_flag <= (op_ff == OP_EQ) ? eq_flag : lt_flag;
            rsp_ff.status       <= ST_OK;
         end
         CMD_OUT_ZD: begin
            rsp_ff.res_num      <= '0;
            rsp_ff.res_den      <= '0;
            rsp_ff.compare_flag <= 1'b0;
            rsp_ff.status       <= ST_ZERO_DEN;
         end
         CMD_OUT_DZ: begin
            rsp_ff.res_num      <= '0;
            rsp_ff.res_den      <= '0;
            rsp_ff.compare_flag <= 1'b0;
            rsp_ff.status       <= ST_DIV_ZERO;
         end
         CMD_OUT_NONE: begin
            rsp_ff.res_num      <= '0;
            rsp_ff.res_den      <= '0;
            rsp_ff.compare_flag <= 1'b0;
            rsp_ff.status       <= ST_OK;
         end
         default: ;
      endcase
   end

   assign stat.zero_den = zden_ff;
   assign stat.x_zero   = (xn_ff == '0);
   assign stat.gcd_done = (u_ff == v_ff);
   assign stat.div_last = (cnt_ff == CW'(DW - 1));
   assign stat.r_zero   = (rm_ff == '0);
   assign stat.op       = op_ff;
   assign rsp_data      = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/core/rau_control.sv
`default_nettype none
module rau_control (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  rau_pkg::dp_stat_type stat,
   output rau_pkg::cmd_type     cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import rau_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_SEL, S_GCD_I, S_GCD_S, S_DIVN_I, S_DIVN_S, S_DIVN_SV,
      S_DIVD_I, S_DIVD_S, S_DIVD_SV, S_STORE, S_OPS, S_MUL_P, S_MUL_Q, S_MUL_D,
      S_ADD, S_MUL_M, S_DV_N, S_DV_D, S_OUT_RES, S_OUT_CMP, S_OUT_ZD, S_OUT_DZ,
      S_OUT_NONE
   } state_type;

   typedef enum logic [1:0] {
      PH_LEFT, PH_RIGHT, PH_RESULT
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = CMD_NOP;
      case (state_ff)
         S_IDLE: begin
            cmd = CMD_LOAD;
            if (start) state_in = S_CHECK;
         end
         S_CHECK: begin
            phase_in = PH_LEFT;
            state_in = stat.zero_den ? S_OUT_ZD : S_SEL;
         end
         S_SEL: begin
            cmd      = (phase_ff == PH_LEFT) ? CMD_SEL_L : CMD_SEL_R;
            state_in = S_GCD_I;
         end
         S_GCD_I: begin
            if (stat.x_zero) begin
               cmd      = CMD_ZERO;
               state_in = S_STORE;
            end else begin
               cmd      = CMD_GCD_INIT;
               state_in = S_GCD_S;
            end
         end
         S_GCD_S: begin
            if (stat.gcd_done) begin
               cmd      = CMD_GCD_FIN;
               state_in = S_DIVN_I;
            end else begin
               cmd = CMD_GCD_STEP;
            end
         end
         S_DIVN_I: begin
            cmd      = CMD_DIV_INIT_N;
            state_in = S_DIVN_S;
         end
         S_DIVN_S: begin
            cmd = CMD_DIV_STEP;
            if (stat.div_last) state_in = S_DIVN_SV;
         end
         S_DIVN_SV: begin
            cmd      = CMD_DIV_SAVE_N;
            state_in = S_DIVD_I;
         end
         S_DIVD_I: begin
            cmd      = CMD_DIV_INIT_D;
            state_in = S_DIVD_S;
         end
         S_DIVD_S: begin
            cmd = CMD_DIV_STEP;
            if (stat.div_last) state_in = S_DIVD_SV;
         end
         S_DIVD_SV: begin
            cmd      = CMD_DIV_SAVE_D;
            state_in = S_STORE;
         end
         S_STORE: begin
            case (phase_ff)
               PH_LEFT: begin
                  cmd      = CMD_ST_L;
                  phase_in = PH_RIGHT;
                  state_in = S_SEL;
               end
               PH_RIGHT: begin
                  cmd      = CMD_ST_R;
                  phase_in = PH_RESULT;
                  state_in = S_OPS;
               end
               default: state_in = S_OUT_RES;
            endcase
         end
         S_OPS: begin
            case (stat.op)
               OP_ADD, OP_SUB, OP_LT: state_in = S_MUL_P;
               OP_MUL: state_in = S_MUL_M;
               OP_DIV: state_in = stat.r_zero ? S_OUT_DZ : S_DV_N;
               OP_EQ: state_in = S_OUT_CMP;
               default: state_in = S_OUT_NONE;
            endcase
         end
         S_MUL_P: begin
            cmd      = CMD_MUL_P;
            state_in = S_MUL_Q;
         end
         S_MUL_Q: begin
            cmd      = CMD_MUL_Q;
            state_in = (stat.op == OP_LT) ? S_OUT_CMP : S_MUL_D;
         end
         S_MUL_D: begin
            cmd      = CMD_MUL_D;
            state_in = (stat.op == OP_MUL) ? S_GCD_I : S_ADD;
         end
         S_ADD: begin
            cmd      = CMD_ADD;
            state_in = S_GCD_I;
         end
         S_MUL_M: begin
            cmd      = CMD_MUL_M;
            state_in = S_MUL_D;
         end
         S_DV_N: begin
            cmd      = CMD_MUL_DVN;
            state_in = S_DV_D;
         end
         S_DV_D: begin
            cmd      = CMD_MUL_DVD;
            state_in = S_GCD_I;
         end
         S_OUT_RES: begin
            cmd      = CMD_OUT_RES;
            state_in = S_IDLE;
         end
         S_OUT_CMP: begin
            cmd      = CMD_OUT_CMP;
            state_in = S_IDLE;
         end
         S_OUT_ZD: begin
            cmd      = CMD_OUT_ZD;
            state_in = S_IDLE;
         end
         S_OUT_DZ: begin
            cmd      = CMD_OUT_DZ;
            state_in = S_IDLE;
         end
         S_OUT_NONE: begin
            cmd      = CMD_OUT_NONE;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= (cmd == CMD_OUT_RES) || (cmd == CMD_OUT_CMP) ||
                         (cmd == CMD_OUT_ZD) || (cmd == CMD_OUT_DZ) ||
                         (cmd == CMD_OUT_NONE);
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted but unit not busy");
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("unit went idle without a result");
`endif

endmodule
`default_nettype wire

// File: tb/sv/rational_arithmetic_unit_test.sv
`default_nettype none
module rational_arithmetic_unit_test;
   import rau_pkg::*;

   localparam int VW = DEFAULT_VALUE_WIDTH;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1950;

   typedef struct {
      bit neg;
      bit [63:0] mag;
      bit [63:0] den;
   } frac_s;

   class rational_scoreboard;
      rsp_type pending[$];
      int errors;

      function bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
         bit [63:0] t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return x;
      endfunction

      function void to_sign_mag(logic [31:0] raw, output bit neg, output bit [63:0] mag);
         bit [63:0] m;
         bit [63:0] x;
         m = (64'd1 << VW) - 1;
         x = {32'd0, raw} & m;
         neg = x[VW-1];
         mag = neg ? (m + 1 - x) : x;
      endfunction

      function frac_s lowest_terms(bit neg, bit [63:0] mag, bit [63:0] den);
         frac_s f;
         bit [63:0] g;
         if (mag == 0) begin
            f.neg = 0;
            f.mag = 0;
            f.den = 1;
         end else begin
            g = gcd64(mag, den);
            f.neg = neg;
            f.mag = mag / g;
            f.den = den / g;
         end
         return f;
      endfunction

      function void signed_sum(bit pn, bit [63:0] pm, bit qn, bit [63:0] qm,
                               output bit rn, output bit [63:0] rm);
         if (pn == qn) begin
            rn = pn;
            rm = pm + qm;
         end else if (pm >= qm) begin
            rn = pn;
            rm = pm - qm;
         end else begin
            rn = qn;
            rm = qm - pm;
         end
         if (rm == 0) rn = 0;
      endfunction

      function void note_request(req_type rq);
         bit an, bn, cn, dn, rn, have;
         bit [63:0] am, bm, cm, dm, pm, qm, rm, rd, lim;
         frac_s l, r, f;
         rsp_type e;
         e = '0;
         lim = (64'd1 << (VW - 1)) - 1;
         to_sign_mag(rq.lhs_num, an, am);
         to_sign_mag(rq.lhs_den, bn, bm);
         to_sign_mag(rq.rhs_num, cn, cm);
         to_sign_mag(rq.rhs_den, dn, dm);
         if (bm == 0 || dm == 0) begin
            e.status = ST_ZERO_DEN;
         end else begin
            l = lowest_terms(an != bn, am, bm);
            r = lowest_terms(cn != dn, cm, dm);
            have = 0;
            rn = 0;
            rm = 0;
            rd = 1;
            pm = l.mag * r.den;
            qm = r.mag * l.den;
            case (rq.op)
               OP_ADD: begin
                  signed_sum(l.neg, pm, r.neg, qm, rn, rm);
                  rd = l.den * r.den;
                  have = 1;
               end
               OP_SUB: begin
                  signed_sum(l.neg, pm, (qm != 0) ? !r.neg : 1'b0, qm, rn, rm);
                  rd = l.den * r.den;
                  have = 1;
               end
               OP_MUL: begin
                  rn = l.neg != r.neg;
                  rm = l.mag * r.mag;
                  rd = l.den * r.den;
                  have = 1;
               end
               OP_DIV: begin
                  if (r.mag == 0) begin
                     e.status = ST_DIV_ZERO;
                  end else begin
                     rn = l.neg != r.neg;
                     rm = l.mag * r.den;
                     rd = l.den * r.mag;
                     have = 1;
                  end
               end
               OP_EQ: e.compare_flag = (l.neg == r.neg && l.mag == r.mag && l.den == r.den);
               OP_LT: begin
                  if (l.neg != r.neg) e.compare_flag = l.neg;
                  else if (!l.neg) e.compare_flag = pm < qm;
                  else e.compare_flag = pm > qm;
               end
               default: ;
            endcase
            if (have) begin
               f = lowest_terms(rn, rm, rd);
               if (f.mag > lim || f.den > lim) begin
                  e.status = ST_OVERFLOW;
               end else begin
                  e.res_num = f.neg ? (32'd0 - f.mag[31:0]) : f.mag[31:0];
                  e.res_den = f.den[30:0];
               end
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.res_num !== e.res_num) begin
            $display("%0t: res_num expected %0d actual %0d", $time, e.res_num, got.res_num);
            errors++;
         end
         if (got.res_den !== e.res_den) begin
            $display("%0t: res_den expected %0d actual %0d", $time, e.res_den, got.res_den);
            errors++;
         end
         if (got.compare_flag !== e.compare_flag) begin
            $display("%0t: compare_flag expected %0b actual %0b", $time, e.compare_flag,
                     got.compare_flag);
            errors++;
         end
         if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_data;
   rational_scoreboard board = new();
   int idle_cycles = 0;

   rational_arithmetic_unit #(.VALUE_WIDTH(VW)) i_dut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req_data);
         if (rsp_valid) board.check_result(rsp_data);
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
         4, 5: return $signed($urandom_range(0, 40)) - 20;
         6: return $signed($urandom_range(0, 2000)) - 1000;
         7: return $urandom_range(1, 12) * ($urandom_range(0, 1) ? 32'd65536 : -32'sd4096);
         default: return $urandom();
      endcase
   endfunction

   task automatic send(logic [2:0] op, logic [31:0] ln, logic [31:0] ld,
                       logic [31:0] rn, logic [31:0] rd);
      req_data <= '{op: op, lhs_num: ln, lhs_den: ld, rhs_num: rn, rhs_den: rd};
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic gap();
      int n;
      n = $urandom_range(0, 9) == 0 ? $urandom_range(10, 300) :
          ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
      if (n > 0) begin
         start <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   initial begin
      logic [31:0] ln, ld, rn, rd;
      logic [2:0] op;
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      for (int k = 0; k < 8; k++) send(3'(k), 32'd3, 32'd4, -32'sd5, 32'd6);
      send(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
      send(OP_EQ, 32'd1, 32'd2, 32'd1, 32'd0);
      send(OP_DIV, 32'd1, 32'd2, 32'd0, -32'sd7);
      send(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
      send(OP_ADD, 32'h8000_0000, 32'd1, 32'd0, 32'd5);
      send(OP_SUB, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
      send(OP_DIV, 32'd1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send(OP_EQ, 32'd2, -32'sd4, -32'sd1, 32'd2);
      send(OP_LT, -32'sd1, 32'd3, 32'd1, 32'd3);
      send(OP_LT, -32'sd1, 32'd3, -32'sd1, 32'd2);
      send(OP_LT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send(OP_SUB, 32'd0, -32'sd9, 32'd0, 32'd3);
      send(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
      start <= 0;
      wait (board.pending.size() == 0);
      @(negedge clock);
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         op = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7)) :
              3'($urandom_range(0, 5));
         ln = pick_value();
         ld = pick_value();
         rn = pick_value();
         rd = pick_value();
         if ($urandom_range(0, 3) == 0) begin
            rn = ln * $urandom_range(1, 3);
            rd = ld * ($urandom_range(0, 1) ? rn / (ln == 0 ? 1 : ln) : 1);
         end
         send(op, ln, ld, rn, rd);
         if ($urandom_range(0, 3) != 0) gap();
         if (k == RANDOM_ITEMS / 2) begin
            start <= 0;
            wait (board.pending.size() == 0);
            @(negedge clock);
         end
      end
      start <= 0;
      wait (board.pending.size() == 0);
      repeat (300) @(posedge clock);
      if (board.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/rau_pkg.sv
rtl/core/rau_datapath.sv
rtl/core/rau_control.sv
rtl/core/rational_arithmetic_unit.sv
tb/sv/rational_arithmetic_unit_test.sv
